// ===== sv/ddm_pkg.sv =====
// Shared types and constants for the decimal digit multiplier.
package ddm_pkg;

  localparam int DIGIT_W   = 4;
  localparam int PRODUCT_W = 54;
  localparam int RADIX     = 10;
  localparam int DIGIT_MAX = (1 << DIGIT_W) - 1;

  typedef struct packed {
    logic [DIGIT_W-1:0] x;
    logic [DIGIT_W-1:0] y;
  } digit_pair_t;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cell_ctrl_t;

endpackage

// ===== sv/decimal_digit_multiplier.sv =====
// Top level: digit cell chain, Horner accumulation, binary multiply and result register.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_stall  | x_digit, y_digit, last
//   result  | out       | out_valid / out_stall| product, too_many_digits
//
// Each accepted digit pair is shifted into the cell chain while it has room.
// After the pair marked last, the chain unloads one digit per cycle into the
// Horner accumulators, one digit for each stored pair, then the accumulators are multiplied;
// the product is registered in S_MULT and shown in state S_OUT.
// in_stall is high from the last transaction until the result is taken.
// Reset clears the control state only; the cells need no clearing.
module decimal_digit_multiplier #(
  parameter int DIGITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ddm_pkg::DIGIT_W-1:0]     x_digit,
  input  logic [ddm_pkg::DIGIT_W-1:0]     y_digit,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ddm_pkg::PRODUCT_W-1:0]   product,
  output logic                            too_many_digits
);

  localparam longint unsigned XMAX =
    64'(ddm_pkg::DIGIT_MAX) * ((64'd10 ** DIGITS) - 64'd1) / 64'd9;
  localparam int XW = $clog2(XMAX + 64'd1);
  localparam int PW = 2 * XW;
  localparam int CW = $clog2(DIGITS + 1);

  typedef enum logic [3:0] {
    S_LOAD   = 4'b0001,
    S_HORNER = 4'b0010,
    S_MULT   = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 ovf;
  logic [XW-1:0]        xacc;
  logic [XW-1:0]        yacc;
  logic [PW-1:0]        prod;
  logic [63:0]          prod_wide;
  logic                 accept;
  logic                 has_room;
  ddm_pkg::cell_ctrl_t  ctrl;
  ddm_pkg::digit_pair_t in_pair;
  ddm_pkg::digit_pair_t cells [DIGITS];

  assign in_stall  = rst || (state != S_LOAD);
  assign accept    = in_valid && !in_stall;
  assign has_room  = count < CW'(DIGITS);
  assign count_next = has_room ? count + CW'(1) : count;

  assign in_pair.x = x_digit;
  assign in_pair.y = y_digit;

  assign ctrl.shift_up   = accept && has_room;
  assign ctrl.shift_down = (state == S_HORNER);

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    ddm_pkg::digit_pair_t lower;
    ddm_pkg::digit_pair_t upper;
    if (i == 0) begin : g_head
      assign lower = in_pair;
    end else begin : g_body
      assign lower = cells[i-1];
    end
    if (i == DIGITS - 1) begin : g_tail
      assign upper = '0;
    end else begin : g_inner
      assign upper = cells[i+1];
    end
    ddm_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .lower (lower),
      .upper (upper),
      .pair  (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            count <= count_next;
            if (!has_room) begin
              ovf <= 1'b1;
            end
            if (last) begin
              state <= S_HORNER;
              xacc  <= '0;
              yacc  <= '0;
            end
          end
        end
        S_HORNER: begin
          xacc  <= XW'(xacc * XW'(ddm_pkg::RADIX)) + XW'(cells[0].x);
          yacc  <= XW'(yacc * XW'(ddm_pkg::RADIX)) + XW'(cells[0].y);
          count <= count - CW'(1);
          if (count == CW'(1)) begin
            state <= S_MULT;
          end
        end
        S_MULT: begin
          prod  <= PW'(xacc) * PW'(yacc);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_LOAD;
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        default: begin
          state <= S_LOAD;
          count <= '0;
          ovf   <= 1'b0;
        end
      endcase
    end
  end

  assign prod_wide       = 64'(prod);
  assign product         = prod_wide[ddm_pkg::PRODUCT_W-1:0];
  assign too_many_digits = ovf;
  assign out_valid       = !rst && (state == S_OUT);

endmodule

// ===== sv/ddm_cell.sv =====
// One digit cell of the chain: holds a digit pair, loads from below, unloads from above.
module ddm_cell (
  input  logic                 clk,
  input  ddm_pkg::cell_ctrl_t  ctrl,
  input  ddm_pkg::digit_pair_t lower,
  input  ddm_pkg::digit_pair_t upper,
  output ddm_pkg::digit_pair_t pair
);

  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      pair <= lower;
    end else if (ctrl.shift_down) begin
      pair <= upper;
    end
  end

endmodule

// ===== sv/ddm_checker.sv =====
// Port-level checks for the decimal digit multiplier, bound to the top level.
module ddm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          last,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ddm_pkg::PRODUCT_W-1:0] product
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(product))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last |=> !out_valid)
    else $error("result after a transaction without last");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall && !out_valid)
    else $error("input not stalled after last transaction");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind decimal_digit_multiplier ddm_checker u_ddm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .product   (product)
);
